FILE: sv/hrrs_pkg.sv
// Shared types, constants and saturation helper for the Hermite crossing search.
package hrrs_pkg;

  localparam int unsigned QW = 33;

  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;

  localparam int NWT_PREP = 0;
  localparam int NWT_POST = 1;

  typedef struct packed {
    logic [30:0]        interval_len;
    logic signed [31:0] value_start;
    logic signed [31:0] value_end;
    logic signed [31:0] slope_start;
    logic signed [31:0] slope_end;
  } in_item_t;

  typedef struct packed {
    logic [30:0] crossing_time;
    logic        found;
    logic        newton_fallback;
  } out_item_t;

  typedef struct packed {
    logic               valid;
    logic               found;
    logic               flag;
    logic [30:0]        len;
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] c3;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [31:0] x;
    logic signed [31:0] p;
    logic signed [31:0] d;
    logic [63:0]        num;
    logic [31:0]        den;
    logic [QW-1:0]      q;
    logic               neg;
    logic               ovf;
  } ctx_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'(SMAX)) begin
      return SMAX;
    end
    if (v < 64'(SMIN)) begin
      return SMIN;
    end
    return v[31:0];
  endfunction

endpackage

FILE: sv/hrrs_if.sv
// Valid/ready stream channel carrying one payload of a chosen type.
interface hrrs_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

FILE: sv/hrrs_setup.sv
// Coefficient set-up cells: threshold offset, slope scaling, Hermite coefficients, end test.
module hrrs_setup #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               valid,
  input  hrrs_pkg::in_item_t item,
  input  logic signed [31:0] threshold,
  output hrrs_pkg::ctx_t     down
);

  localparam logic signed [31:0] ONE = 32'(64'd1 << FRAC_BITS);

  typedef struct packed {
    logic               valid;
    logic [30:0]        len;
    logic signed [31:0] f1;
    logic signed [31:0] f2;
    logic signed [31:0] d1;
    logic signed [31:0] d2;
  } s1_t;

  typedef struct packed {
    logic               valid;
    logic [30:0]        len;
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] c3;
  } s2_t;

  s1_t s1, s1_next;
  s2_t s2, s2_next;
  hrrs_pkg::ctx_t s3_next;
  logic signed [63:0] pr1, pr2;
  logic signed [31:0] e, t1, t2, p1;

  assign pr1 = item.slope_start * $signed({1'b0, item.interval_len});
  assign pr2 = item.slope_end * $signed({1'b0, item.interval_len});

  always_comb begin
    s1_next.valid = valid;
    s1_next.len   = item.interval_len;
    s1_next.f1    = hrrs_pkg::sat32(64'(item.value_start) - 64'(threshold));
    s1_next.f2    = hrrs_pkg::sat32(64'(item.value_end) - 64'(threshold));
    s1_next.d1    = hrrs_pkg::sat32(pr1 >>> FRAC_BITS);
    s1_next.d2    = hrrs_pkg::sat32(pr2 >>> FRAC_BITS);
  end

  always_comb begin
    e             = hrrs_pkg::sat32(64'(s1.f1) - 64'(s1.f2));
    s2_next.valid = s1.valid;
    s2_next.len   = s1.len;
    s2_next.c0    = s1.f1;
    s2_next.c1    = s1.d1;
    s2_next.c2    = hrrs_pkg::sat32(-64'sd2 * 64'(s1.d1) - 64'(s1.d2) - 64'sd3 * 64'(e));
    s2_next.c3    = hrrs_pkg::sat32(64'(s1.d1) + 64'(s1.d2) + 64'sd2 * 64'(e));
  end

  // At x = 1.0 each Horner product returns its operand unchanged.
  always_comb begin
    t1 = hrrs_pkg::sat32(64'(s2.c3) + 64'(s2.c2));
    t2 = hrrs_pkg::sat32(64'(t1) + 64'(s2.c1));
    p1 = hrrs_pkg::sat32(64'(t2) + 64'(s2.c0));
    s3_next       = '0;
    s3_next.valid = s2.valid;
    s3_next.found = (s2.c0 <= 0) && (p1 >= 0);
    s3_next.len   = s2.len;
    s3_next.c0    = s2.c0;
    s3_next.c1    = s2.c1;
    s3_next.c2    = s2.c2;
    s3_next.c3    = s2.c3;
    s3_next.lo    = '0;
    s3_next.hi    = ONE;
    s3_next.x     = ONE >>> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid   <= 1'b0;
      s2.valid   <= 1'b0;
      down.valid <= 1'b0;
    end else if (en) begin
      s1   <= s1_next;
      s2   <= s2_next;
      down <= s3_next;
    end
  end

endmodule

FILE: sv/hrrs_eval_cell.sv
// One Horner step of the polynomial, and in steps 0 and 1 also of its derivative, at the current point.
module hrrs_eval_cell #(
  parameter int FRAC_BITS = 16,
  parameter int STEP      = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  hrrs_pkg::ctx_t up,
  output hrrs_pkg::ctx_t down
);

  hrrs_pkg::ctx_t down_next;
  logic signed [31:0] a_p, a_d, k_p, k_d;
  logic signed [63:0] m_p, m_d;

  always_comb begin
    case (STEP)
      0: begin
        a_p = up.c3;
        k_p = up.c2;
        a_d = hrrs_pkg::sat32(64'(up.c3) + 64'(up.c3) + 64'(up.c3));
        k_d = hrrs_pkg::sat32(64'(up.c2) + 64'(up.c2));
      end
      1: begin
        a_p = up.p;
        k_p = up.c1;
        a_d = up.d;
        k_d = up.c1;
      end
      default: begin
        a_p = up.p;
        k_p = up.c0;
        a_d = up.d;
        k_d = up.c1;
      end
    endcase
  end

  assign m_p = a_p * up.x;
  assign m_d = a_d * up.x;

  always_comb begin
    down_next   = up;
    down_next.p = hrrs_pkg::sat32((m_p >>> FRAC_BITS) + 64'(k_p));
    if (STEP < 2) begin
      down_next.d = hrrs_pkg::sat32((m_d >>> FRAC_BITS) + 64'(k_d));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down.valid <= 1'b0;
    end else if (en) begin
      down <= down_next;
    end
  end

endmodule

FILE: sv/hrrs_bisect_cell.sv
// Bracket update of one bisection step and choice of the next midpoint.
module hrrs_bisect_cell #(
  parameter bit LAST = 1'b0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  hrrs_pkg::ctx_t up,
  output hrrs_pkg::ctx_t down
);

  hrrs_pkg::ctx_t down_next;
  logic signed [32:0] sum;

  always_comb begin
    down_next = up;
    if (up.p <= 0) begin
      down_next.lo = up.x;
    end else begin
      down_next.hi = up.x;
    end
    sum = 33'(down_next.lo) + 33'(down_next.hi);
    // The last step keeps the evaluated point as the Newton start.
    if (!LAST) begin
      down_next.x = sum[32:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down.valid <= 1'b0;
    end else if (en) begin
      down <= down_next;
    end
  end

endmodule

FILE: sv/hrrs_div_cell.sv
// One restoring quotient bit of the Newton correction division.
module hrrs_div_cell #(
  parameter int BIT = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  hrrs_pkg::ctx_t up,
  output hrrs_pkg::ctx_t down
);

  hrrs_pkg::ctx_t down_next;
  logic [63:0] sub;

  always_comb begin
    down_next = up;
    sub       = 64'(up.den) << BIT;
    if (up.num >= sub) begin
      down_next.num    = up.num - sub;
      down_next.q[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down.valid <= 1'b0;
    end else if (en) begin
      down <= down_next;
    end
  end

endmodule

FILE: sv/hrrs_newton_cell.sv
// Newton step set-up (operand magnitudes, zero slope) or update (signed, saturated step).
module hrrs_newton_cell #(
  parameter int FRAC_BITS = 16,
  parameter int MODE      = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  hrrs_pkg::ctx_t up,
  output hrrs_pkg::ctx_t down
);

  hrrs_pkg::ctx_t down_next;
  logic signed [32:0] px, dx, ap, ad;
  logic signed [34:0] qs;

  always_comb begin
    down_next = up;
    px = 33'(up.p);
    dx = 33'(up.d);
    ap = (px < 0) ? -px : px;
    ad = (dx < 0) ? -dx : dx;
    qs = up.neg ? -$signed({2'b00, up.q}) : $signed({2'b00, up.q});
    case (MODE)
      hrrs_pkg::NWT_PREP: begin
        down_next.flag = up.flag | (up.d == 0);
        down_next.num  = 64'(ap[31:0]) << FRAC_BITS;
        down_next.den  = ad[31:0];
        down_next.neg  = up.p[31] ^ up.d[31];
        down_next.q    = '0;
        down_next.ovf  = 65'(down_next.num) >= (65'(ad[31:0]) << hrrs_pkg::QW);
      end
      default: begin
        if (up.ovf) begin
          down_next.x = up.neg ? hrrs_pkg::SMAX : hrrs_pkg::SMIN;
        end else begin
          down_next.x = hrrs_pkg::sat32(64'(up.x) - 64'(qs));
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down.valid <= 1'b0;
    end else if (en) begin
      down <= down_next;
    end
  end

endmodule

FILE: sv/hermite_rising_root_search.sv
// Throughput: one transaction per cycle while the result buffer has room; every cell of the chain advances together.
// The chain stalls only when both entries of the two-entry result buffer are occupied.
// A Newton step costs 38 cells, 33 of them one bit each of the restoring division.
// Reset (rst, synchronous, active high) empties the chain and buffer, threshold reads 0.
module hermite_rising_root_search #(
  parameter int BISECT_STEPS = 6,
  parameter int NEWTON_STEPS = 4,
  parameter int FRAC_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  hrrs_if.sink        req,
  hrrs_if.source      rsp
);

  // Each bisection step is three Horner cells and one bracket cell; each Newton
  // step is three Horner cells, a set-up cell, the division cells and an update cell.
  localparam int BIS_LEN  = 4;
  localparam int NWT_LEN  = 5 + hrrs_pkg::QW;
  localparam int NWT_BASE = BIS_LEN * BISECT_STEPS;
  localparam int N_CELLS  = NWT_BASE + NWT_LEN * NEWTON_STEPS;

  logic signed [31:0] threshold;
  logic               en;
  logic               accept;
  hrrs_pkg::ctx_t     chain [0:N_CELLS];

  // The user must write the threshold only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  // Result buffer: two entries, so that the chain keeps moving while one result waits.
  hrrs_pkg::out_item_t slot0, slot1, fin_item;
  logic [1:0]          count;
  logic                push, pop;

  assign en        = (count != 2'd2);
  assign req.ready = en;
  assign accept    = req.valid && req.ready;

  hrrs_setup #(.FRAC_BITS(FRAC_BITS)) u_setup (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid     (accept),
    .item      (req.payload),
    .threshold (threshold),
    .down      (chain[0])
  );

  genvar b, s, n, k;
  generate
    for (b = 0; b < BISECT_STEPS; b++) begin : g_bis
      for (s = 0; s < 3; s++) begin : g_ev
        hrrs_eval_cell #(.FRAC_BITS(FRAC_BITS), .STEP(s)) u_ev (
          .clk (clk), .rst (rst), .en (en),
          .up (chain[BIS_LEN*b + s]), .down (chain[BIS_LEN*b + s + 1])
        );
      end
      hrrs_bisect_cell #(.LAST(b == BISECT_STEPS - 1)) u_bis (
        .clk (clk), .rst (rst), .en (en),
        .up (chain[BIS_LEN*b + 3]), .down (chain[BIS_LEN*b + 4])
      );
    end

    for (n = 0; n < NEWTON_STEPS; n++) begin : g_nwt
      for (s = 0; s < 3; s++) begin : g_ev
        hrrs_eval_cell #(.FRAC_BITS(FRAC_BITS), .STEP(s)) u_ev (
          .clk (clk), .rst (rst), .en (en),
          .up (chain[NWT_BASE + NWT_LEN*n + s]),
          .down (chain[NWT_BASE + NWT_LEN*n + s + 1])
        );
      end
      hrrs_newton_cell #(.FRAC_BITS(FRAC_BITS), .MODE(hrrs_pkg::NWT_PREP)) u_prep (
        .clk (clk), .rst (rst), .en (en),
        .up (chain[NWT_BASE + NWT_LEN*n + 3]),
        .down (chain[NWT_BASE + NWT_LEN*n + 4])
      );
      for (k = 0; k < hrrs_pkg::QW; k++) begin : g_div
        hrrs_div_cell #(.BIT(hrrs_pkg::QW - 1 - k)) u_div (
          .clk (clk), .rst (rst), .en (en),
          .up (chain[NWT_BASE + NWT_LEN*n + 4 + k]),
          .down (chain[NWT_BASE + NWT_LEN*n + 5 + k])
        );
      end
      hrrs_newton_cell #(.FRAC_BITS(FRAC_BITS), .MODE(hrrs_pkg::NWT_POST)) u_post (
        .clk (clk), .rst (rst), .en (en),
        .up (chain[NWT_BASE + NWT_LEN*n + 4 + hrrs_pkg::QW]),
        .down (chain[NWT_BASE + NWT_LEN*n + 5 + hrrs_pkg::QW])
      );
    end
  endgenerate

  // Finish, first register: a point outside the final bracket, or a zero
  // derivative met on the way, falls back to the bracket midpoint.
  hrrs_pkg::ctx_t     tail;
  logic               fa_valid, fa_found, fa_flag;
  logic [30:0]        fa_len, fa_x;
  logic               fa_flag_next;
  logic signed [32:0] mid_sum;
  logic signed [31:0] fa_x_next;

  assign tail = chain[N_CELLS];

  always_comb begin
    mid_sum      = 33'(tail.lo) + 33'(tail.hi);
    fa_flag_next = tail.flag || (tail.x < tail.lo) || (tail.x > tail.hi);
    fa_x_next    = fa_flag_next ? mid_sum[32:1] : tail.x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fa_valid <= 1'b0;
    end else if (en) begin
      fa_valid <= tail.valid;
      fa_found <= tail.found;
      fa_flag  <= fa_flag_next;
      fa_len   <= tail.len;
      fa_x     <= fa_x_next[30:0];
    end
  end

  // Finish, second register: scale the normalised point back by the interval length.
  logic [61:0] scaled;
  logic        fb_valid;

  assign scaled = 62'(fa_x) * 62'(fa_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_valid <= 1'b0;
    end else if (en) begin
      fb_valid <= fa_valid;
      if (fa_found) begin
        fin_item.crossing_time   <= scaled[FRAC_BITS +: 31];
        fin_item.found           <= 1'b1;
        fin_item.newton_fallback <= fa_flag;
      end else begin
        fin_item <= '0;
      end
    end
  end

  assign push        = fb_valid && en;
  assign pop         = rsp.valid && rsp.ready;
  assign rsp.valid   = (count != 2'd0);
  assign rsp.payload = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      if (push && !pop) begin
        count <= count + 2'd1;
        if (count == 2'd0) begin
          slot0 <= fin_item;
        end else begin
          slot1 <= fin_item;
        end
      end else if (push && pop) begin
        // Only reached with one entry held, as a full buffer blocks the push.
        slot0 <= fin_item;
      end else if (pop) begin
        count <= count - 2'd1;
        slot0 <= slot1;
      end
    end
  end

endmodule

FILE: sv/hrrs_checker.sv
// Port-level checks on the crossing search block, attached by bind.
module hrrs_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [30:0] rsp_time,
  input logic        rsp_found,
  input logic        rsp_fallback
);

  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_found |-> (rsp_time == 31'd0) && !rsp_fallback)
    else $error("result without a crossing carries a time or a fallback flag");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_time) && $stable(rsp_found)
      && $stable(rsp_fallback))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result shown straight after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("input refused while no result is pending");

endmodule

bind hermite_rising_root_search hrrs_port_checks u_hrrs_port_checks (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_time     (rsp.payload.crossing_time),
  .rsp_found    (rsp.payload.found),
  .rsp_fallback (rsp.payload.newton_fallback)
);
